FILE: rtl/lcdt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LCD mode timing package
// Shared widths, mode codes, STAT enable bit positions and the structs that
// pass timing state and result words between the step logic and the top.
// ----------------------------------------------------------------------------
package lcdt_pkg;

  localparam int CNT_W  = 9;   // line cycle counter
  localparam int LINE_W = 8;   // scanline number
  localparam int MODE_W = 2;

  localparam int OAM_SPAN      = 80;
  localparam int TRANSFER_SPAN = 172;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_HBLANK   = 2'd0;
  localparam mode_t MODE_VBLANK   = 2'd1;
  localparam mode_t MODE_OAM      = 2'd2;
  localparam mode_t MODE_TRANSFER = 2'd3;

  // positions within stat_enables (STAT bits 3..6)
  localparam int EN_HBLANK = 0;
  localparam int EN_VBLANK = 1;
  localparam int EN_OAM    = 2;
  localparam int EN_LYC    = 3;

  typedef struct packed {
    logic [CNT_W-1:0]  cycle_count;
    logic [LINE_W-1:0] current_line;
    mode_t             current_mode;
    logic              coincidence_flag;
  } lcdt_state_t;

  typedef struct packed {
    logic [LINE_W-1:0] line;
    mode_t             mode;
    logic              coincidence;
    logic              vblank_request;
    logic              stat_request;
    logic              render_strobe;
    logic [LINE_W-1:0] render_index;
  } lcdt_result_t;

endpackage
`default_nettype wire

FILE: rtl/lcdt_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LCD mode timing step
// Combinational next-state and result for one input word carrying an elapsed cycle count.
// ----------------------------------------------------------------------------
module lcdt_step #(
  parameter int LINE_CYCLES   = 456,
  parameter int VISIBLE_LINES = 144,
  parameter int LAST_LINE     = 153
) (
  input  lcdt_pkg::lcdt_state_t  state,
  input  logic [4:0]             cycles,
  input  logic                   lcd_enable,
  input  logic [7:0]             compare_line,
  input  logic [3:0]             stat_enables,
  output lcdt_pkg::lcdt_state_t  state_nxt,
  output lcdt_pkg::lcdt_result_t result
);
  import lcdt_pkg::*;

  localparam logic [CNT_W-1:0]  LINE_CNT = CNT_W'(LINE_CYCLES);
  localparam logic [CNT_W-1:0]  OAM_EDGE = CNT_W'(LINE_CYCLES - OAM_SPAN);
  localparam logic [CNT_W-1:0]  XFER_EDGE =
    CNT_W'(LINE_CYCLES - OAM_SPAN - TRANSFER_SPAN);
  localparam logic [LINE_W-1:0] VIS_LINE = LINE_W'(VISIBLE_LINES);
  localparam logic [LINE_W-1:0] END_LINE = LINE_W'(LAST_LINE);

  always_comb begin
    logic              want;
    logic [LINE_W-1:0] nl;

    want      = 1'b0;
    nl        = state.current_line + 1'b1;
    state_nxt = state;
    result    = '0;

    if (!lcd_enable) begin
      state_nxt.cycle_count  = LINE_CNT;
      state_nxt.current_line = '0;
      state_nxt.current_mode = MODE_VBLANK;
    end else begin
      // mode judged from the count held before this word's countdown
      if (state.current_line >= VIS_LINE) begin
        state_nxt.current_mode = MODE_VBLANK;
        want = stat_enables[EN_VBLANK];
      end else if (state.cycle_count >= OAM_EDGE) begin
        state_nxt.current_mode = MODE_OAM;
        want = stat_enables[EN_OAM];
      end else if (state.cycle_count >= XFER_EDGE) begin
        state_nxt.current_mode = MODE_TRANSFER;
      end else begin
        state_nxt.current_mode = MODE_HBLANK;
        want = stat_enables[EN_HBLANK];
      end

      if (want && (state_nxt.current_mode != state.current_mode)) begin
        result.stat_request = 1'b1;
      end

      state_nxt.coincidence_flag = (state.current_line == compare_line);
      if (state_nxt.coincidence_flag && stat_enables[EN_LYC]) begin
        result.stat_request = 1'b1;
      end

      if (CNT_W'(cycles) >= state.cycle_count) begin
        // line done; leftover cycles are dropped
        state_nxt.cycle_count  = LINE_CNT;
        state_nxt.current_line = nl;
        if (nl == VIS_LINE) begin
          result.vblank_request = 1'b1;
        end else if (nl > END_LINE) begin
          state_nxt.current_line = '0;
        end else if (nl < VIS_LINE) begin
          result.render_strobe = 1'b1;
          result.render_index  = nl;
        end
      end else begin
        state_nxt.cycle_count = state.cycle_count - CNT_W'(cycles);
      end
    end

    result.line        = state_nxt.current_line;
    result.mode        = state_nxt.current_mode;
    result.coincidence = state_nxt.coincidence_flag;
  end

endmodule
`default_nettype wire

FILE: rtl/lcd_scanline_mode_timing_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LCD scanline and mode timing
// Tracks scanline, LCD mode and interrupt requests from the elapsed CPU time in each input word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one word per CPU instruction carrying the elapsed
//   cycle count, LCD enable, LY compare value and STAT interrupt enables.
//   Result channel (out_*): one word per input word with the line, mode,
//   coincidence flag, vblank/STAT requests and the render strobe and index.
//   A word is presented on out_* in the cycle after it is taken. Throughput is
//   one word per clock while in_stall is low; the timing state updates in
//   the same edge that takes the word, so the next word sees it directly.
//   The result register frees itself in the cycle it is taken, so in_stall
//   is high only while a result is held and out_stall is high.
//   Under out_stall with a result held, it stays held and no new word is taken.
//   Reset (rst_n low, synchronous) empties the result register and sets the
//   counter to a full line, line 0, mode 0, coincidence clear.
// ----------------------------------------------------------------------------
module lcd_scanline_mode_timing_top #(
  parameter int LINE_CYCLES   = 456,
  parameter int VISIBLE_LINES = 144,
  parameter int LAST_LINE     = 153
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [4:0] in_cycles,
  input  logic       in_lcd_enable,
  input  logic [7:0] in_compare_line,
  input  logic [3:0] in_stat_enables,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_line,
  output logic [1:0] out_mode,
  output logic       out_coincidence,
  output logic       out_vblank_request,
  output logic       out_stat_request,
  output logic       out_render_strobe,
  output logic [7:0] out_render_index
);
  import lcdt_pkg::*;

  localparam int MAX_LINE =
    (LAST_LINE > VISIBLE_LINES) ? LAST_LINE : VISIBLE_LINES;

  lcdt_state_t  state_r, state_nxt;
  lcdt_result_t result_r, result_nxt;
  logic         out_valid_r;
  logic         in_accept;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  lcdt_step #(
    .LINE_CYCLES   (LINE_CYCLES),
    .VISIBLE_LINES (VISIBLE_LINES),
    .LAST_LINE     (LAST_LINE)
  ) u_step (
    .state        (state_r),
    .cycles       (in_cycles),
    .lcd_enable   (in_lcd_enable),
    .compare_line (in_compare_line),
    .stat_enables (in_stat_enables),
    .state_nxt    (state_nxt),
    .result       (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.cycle_count      <= CNT_W'(LINE_CYCLES);
      state_r.current_line     <= '0;
      state_r.current_mode     <= MODE_HBLANK;
      state_r.coincidence_flag <= 1'b0;
      out_valid_r              <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_line           = result_r.line;
  assign out_mode           = result_r.mode;
  assign out_coincidence    = result_r.coincidence;
  assign out_vblank_request = result_r.vblank_request;
  assign out_stat_request   = result_r.stat_request;
  assign out_render_strobe  = result_r.render_strobe;
  assign out_render_index   = result_r.render_index;

`ifndef SYNTHESIS
  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.current_line <= LINE_W'(MAX_LINE))
    else $error("scanline beyond last line");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.cycle_count != '0) && (state_r.cycle_count <= CNT_W'(LINE_CYCLES)))
    else $error("line cycle counter out of range");

  a_lcd_off: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !in_lcd_enable |=>
      out_valid_r && (out_mode == MODE_VBLANK) && (out_line == '0) &&
      !out_stat_request && !out_vblank_request && !out_render_strobe)
    else $error("LCD off word produced activity");

  a_strobe_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      (out_render_strobe ? (out_render_index != '0 &&
                            out_render_index < LINE_W'(VISIBLE_LINES))
                         : (out_render_index == '0)))
    else $error("render index inconsistent with strobe");

  a_free_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled with empty result register");
`endif

endmodule
`default_nettype wire
